### rtl/core/lld_pkg.sv
`timescale 1ns / 1ps
// constants and field widths of the least-loaded dispatcher
// no dependencies

package lld_pkg;

  localparam int unsigned OP_W     = 1;
  localparam int unsigned SIDX_W   = 4;
  localparam int unsigned LOAD_W   = 32;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned ACTIVE_W = 5;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  localparam logic [OP_W-1:0] OP_REQUEST = 1'b0;
  localparam logic [OP_W-1:0] OP_REPORT  = 1'b1;

  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

endpackage

### rtl/core/lld_req_if.sv
`timescale 1ns / 1ps
// request and load report channel of the least-loaded dispatcher
// depends on lld_pkg

interface lld_req_if;
  import lld_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [SIDX_W-1:0]   server_index;
  logic [LOAD_W-1:0]   time_value;
  logic [ADDR_W-1:0]   source_address;
  logic [ADDR_W-1:0]   dest_address;

  modport source (
    output valid, operation, server_index, time_value, source_address, dest_address,
    input  ready
  );
  modport sink (
    input  valid, operation, server_index, time_value, source_address, dest_address,
    output ready
  );
endinterface

### rtl/core/lld_res_if.sv
`timescale 1ns / 1ps
// dispatch result channel of the least-loaded dispatcher
// depends on lld_pkg

interface lld_res_if;
  import lld_pkg::*;

  logic                valid;
  logic                ready;
  logic [SIDX_W-1:0]   target_server;
  logic [ADDR_W-1:0]   out_source_address;
  logic [ADDR_W-1:0]   out_dest_address;
  logic [LOAD_W-1:0]   service_time;
  logic [LOAD_W-1:0]   load_after;

  modport source (
    output valid, target_server, out_source_address, out_dest_address, service_time,
           load_after,
    input  ready
  );
  modport sink (
    input  valid, target_server, out_source_address, out_dest_address, service_time,
           load_after,
    output ready
  );
endinterface

### rtl/core/lld_cell.sv
`timescale 1ns / 1ps
// one server cell: holds that server's load and passes the search token on
// depends on lld_pkg

module lld_cell #(
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_en_i,
  input  logic [lld_pkg::LOAD_W-1:0] wr_data_i,
  input  logic                       active_i,
  input  logic                       tok_valid_i,
  input  logic [IDX_W-1:0]           tok_idx_i,
  input  logic [lld_pkg::LOAD_W-1:0] tok_load_i,
  output logic                       tok_valid_o,
  output logic [IDX_W-1:0]           tok_idx_o,
  output logic [lld_pkg::LOAD_W-1:0] tok_load_o
);
  import lld_pkg::*;

  logic [LOAD_W-1:0] load_q;
  logic              take;
  logic              tok_valid_q;
  logic [IDX_W-1:0]  tok_idx_q;
  logic [LOAD_W-1:0] tok_load_q;

  // ties go to the later cell, hence less-or-equal
  assign take = active_i && (load_q <= tok_load_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q      <= '0;
      tok_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        load_q <= wr_data_i;
      end
      tok_valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      tok_idx_q  <= IDX_W'(CELL_IDX);
      tok_load_q <= load_q;
    end else begin
      tok_idx_q  <= tok_idx_i;
      tok_load_q <= tok_load_i;
    end
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_idx_o   = tok_idx_q;
  assign tok_load_o  = tok_load_q;

endmodule

### rtl/core/least_loaded_dispatcher.sv
`timescale 1ns / 1ps
// least-loaded dispatcher top level: config register, cell row, write-back, result register
// depends on lld_pkg, lld_req_if, lld_res_if, lld_cell
//
// usage
//   req_i carries client requests and server load reports; res_o carries one result per
//   request and none per report. a transfer happens when valid and ready are both high.
//   cfg_we_i/cfg_wdata_i write the active server count; write it only while idle.
//   a report updates the addressed server's load in the cycle it is accepted and the
//   next item may follow in the next cycle.
//   a request sends a search token down the row of MAX_SERVERS cells, one cell per
//   cycle; the result then passes the finish register and the output register before
//   it is valid. one request is in flight at a time, and no new item is taken until
//   the search has ended and its result has been written to the output register.
//   the result sits in an output register; a stalled receiver holds it, and a later
//   request completes its search and then waits for that register to drain.
//   reset clears every server load to zero, sets the active count to 16 and empties
//   the pipeline.

module least_loaded_dispatcher #(
  parameter int unsigned MAX_SERVERS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lld_pkg::ACTIVE_W-1:0] cfg_wdata_i,
  lld_req_if.sink                      req_i,
  lld_res_if.source                    res_o
);
  import lld_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_SERVERS);

  logic [ACTIVE_W-1:0] active_q;

  logic [LOAD_W-1:0]   tval_q;
  logic [ADDR_W-1:0]   src_q;
  logic [ADDR_W-1:0]   dst_q;

  logic                search_q;
  logic                fin_valid_q;
  logic [IDX_W-1:0]    fin_idx_q;
  logic [LOAD_W-1:0]   fin_load_q;

  logic                out_valid_q;
  logic [SIDX_W-1:0]   out_target_q;
  logic [ADDR_W-1:0]   out_src_q;
  logic [ADDR_W-1:0]   out_dst_q;
  logic [LOAD_W-1:0]   out_time_q;
  logic [LOAD_W-1:0]   out_load_q;

  logic                accept;
  logic                start;
  logic                rep_we;
  logic                wb;
  logic [LOAD_W:0]     sum;
  logic [LOAD_W-1:0]   sum_sat;
  logic [LOAD_W-1:0]   wr_data;

  logic [MAX_SERVERS:0]             tok_v;
  logic [IDX_W-1:0]                 tok_idx  [MAX_SERVERS+1];
  logic [LOAD_W-1:0]                tok_load [MAX_SERVERS+1];
  logic [MAX_SERVERS-1:0]           cell_we;
  logic [MAX_SERVERS-1:0]           cell_active;

  assign req_i.ready = !search_q && !fin_valid_q;
  assign accept      = req_i.valid && req_i.ready;
  assign start       = accept && (req_i.operation == OP_REQUEST);
  assign rep_we      = accept && (req_i.operation == OP_REPORT)
                    && (32'(req_i.server_index) < 32'(MAX_SERVERS));

  assign wb      = fin_valid_q && (!out_valid_q || res_o.ready);
  assign sum     = {1'b0, fin_load_q} + {1'b0, tval_q};
  assign sum_sat = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
  assign wr_data = fin_valid_q ? sum_sat : req_i.time_value;

  // the first cell always wins against this token
  assign tok_v[0]    = start;
  assign tok_idx[0]  = '0;
  assign tok_load[0] = LOAD_MAX;

  for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
    // count zero still keeps server 0 in play
    assign cell_active[g] = (g == 0) || (32'(g) < 32'(active_q));
    assign cell_we[g]     = (wb && (32'(fin_idx_q) == 32'(g)))
                         || (rep_we && (32'(req_i.server_index) == 32'(g)));

    lld_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .wr_en_i     (cell_we[g]),
      .wr_data_i   (wr_data),
      .active_i    (cell_active[g]),
      .tok_valid_i (tok_v[g]),
      .tok_idx_i   (tok_idx[g]),
      .tok_load_i  (tok_load[g]),
      .tok_valid_o (tok_v[g+1]),
      .tok_idx_o   (tok_idx[g+1]),
      .tok_load_o  (tok_load[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= ACTIVE_RESET;
      search_q    <= 1'b0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (start) begin
        search_q <= 1'b1;
      end else if (tok_v[MAX_SERVERS]) begin
        search_q <= 1'b0;
      end
      if (tok_v[MAX_SERVERS]) begin
        fin_valid_q <= 1'b1;
      end else if (wb) begin
        fin_valid_q <= 1'b0;
      end
      if (wb) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      tval_q <= req_i.time_value;
      src_q  <= req_i.source_address;
      dst_q  <= req_i.dest_address;
    end
    if (tok_v[MAX_SERVERS]) begin
      fin_idx_q  <= tok_idx[MAX_SERVERS];
      fin_load_q <= tok_load[MAX_SERVERS];
    end
    if (wb) begin
      out_target_q <= SIDX_W'(fin_idx_q);
      out_src_q    <= src_q;
      out_dst_q    <= dst_q;
      out_time_q   <= tval_q;
      out_load_q   <= sum_sat;
    end
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.target_server      = out_target_q;
  assign res_o.out_source_address = out_src_q;
  assign res_o.out_dest_address   = out_dst_q;
  assign res_o.service_time       = out_time_q;
  assign res_o.load_after         = out_load_q;

endmodule

### tb/sv/least_loaded_dispatcher_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the least-loaded dispatcher: directed and random requests,
// load reports and active server settings, each dispatch checked against a local model
// depends on lld_pkg, lld_req_if, lld_res_if and least_loaded_dispatcher

module least_loaded_dispatcher_test;
  import lld_pkg::*;

  localparam int unsigned MAX_SERVERS    = 16;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [SIDX_W-1:0] target_server;
    logic [ADDR_W-1:0] source_address;
    logic [ADDR_W-1:0] dest_address;
    logic [LOAD_W-1:0] service_time;
    logic [LOAD_W-1:0] load_after;
  } dispatch_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [ACTIVE_W-1:0] cfg_wdata;

  lld_req_if req_if ();
  lld_res_if res_if ();

  least_loaded_dispatcher #(
    .MAX_SERVERS(MAX_SERVERS)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .res_o      (res_if)
  );

  logic [LOAD_W-1:0]   server_load_model [MAX_SERVERS];
  logic [ACTIVE_W-1:0] active_model;
  dispatch_t           pending_dispatches [$];
  bit                  gaps_on = 1'b1;
  int unsigned         quiet_cycles = 0;
  int unsigned         errors = 0;
  int unsigned         n_requests = 0;
  int unsigned         n_reports = 0;
  int unsigned         n_checked = 0;
  int unsigned         n_settings = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // picks the server for a request and books its service time; a report sets the model load
  function automatic void predict_dispatch(input logic [OP_W-1:0]   op,
                                           input logic [SIDX_W-1:0] sidx,
                                           input logic [LOAD_W-1:0] tval,
                                           input logic [ADDR_W-1:0] src,
                                           input logic [ADDR_W-1:0] dst);
    int unsigned     live;
    int unsigned     best;
    int unsigned     i;
    logic [LOAD_W:0] sum;
    dispatch_t       d;
    if (op == OP_REPORT) begin
      if (sidx < MAX_SERVERS) server_load_model[sidx] = tval;
      n_reports++;
      return;
    end
    live = (active_model == 0) ? 1 : active_model;
    if (live > MAX_SERVERS) live = MAX_SERVERS;
    best = 0;
    for (i = 1; i < live; i++) begin
      if (server_load_model[i] <= server_load_model[best]) best = i;
    end
    sum = {1'b0, server_load_model[best]} + {1'b0, tval};
    server_load_model[best] = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
    d.target_server  = SIDX_W'(best);
    d.source_address = src;
    d.dest_address   = dst;
    d.service_time   = tval;
    d.load_after     = server_load_model[best];
    pending_dispatches.insert(pending_dispatches.size(), d);
    n_requests++;
  endfunction

  task automatic send_item(input logic [OP_W-1:0]   op,
                           input logic [SIDX_W-1:0] sidx,
                           input logic [LOAD_W-1:0] tval,
                           input logic [ADDR_W-1:0] src,
                           input logic [ADDR_W-1:0] dst);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 16) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid          = 1'b1;
    req_if.operation      = op;
    req_if.server_index   = sidx;
    req_if.time_value     = tval;
    req_if.source_address = src;
    req_if.dest_address   = dst;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    predict_dispatch(op, sidx, tval, src, dst);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending_dispatches.size() != 0) @(negedge clk);
  endtask

  task automatic set_active_servers(input logic [ACTIVE_W-1:0] count);
    wait_for_results();
    repeat (MAX_SERVERS + 4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = count;
    @(negedge clk);
    cfg_we       = 1'b0;
    active_model = count;
    n_settings++;
  endtask

  // all loads zero after reset, so ties pick the highest index
  task automatic test_reset_ties();
    send_item(OP_REQUEST, 4'h0, 32'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_item(OP_REQUEST, 4'hF, 32'd0, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(OP_REQUEST, 4'h5, 32'd1, 32'hC0A8_0001, 32'h0A00_0001);
    send_item(OP_REQUEST, 4'hA, 32'd1, 32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  task automatic test_load_reports();
    send_item(OP_REPORT, 4'hF, LOAD_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_REPORT, 4'hE, LOAD_MAX, 32'h0, 32'h0);
    send_item(OP_REPORT, 4'h3, 32'd5, 32'h0, 32'h0);
    send_item(OP_REPORT, 4'h0, 32'd0, 32'h0, 32'h0);
    send_item(OP_REQUEST, 4'h3, 32'd7, 32'h7F00_0001, 32'h8000_0000);
    send_item(OP_REQUEST, 4'h0, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  // zero and oversized counts, reports to inactive servers, saturation of the load
  task automatic test_active_count();
    set_active_servers(5'd0);
    send_item(OP_REPORT, 4'h0, 32'hFFFF_FFF0, 32'h0, 32'h0);
    send_item(OP_REQUEST, 4'h7, 32'hFFFF_FFFF, 32'h0102_0304, 32'h0506_0708);
    send_item(OP_REQUEST, 4'h8, 32'd0, 32'h1111_1111, 32'h2222_2222);
    set_active_servers(5'd1);
    send_item(OP_REPORT, 4'h5, 32'd0, 32'h0, 32'h0);
    send_item(OP_REQUEST, 4'h5, 32'd3, 32'h3333_3333, 32'h4444_4444);
    set_active_servers(5'd31);
    send_item(OP_REQUEST, 4'h1, 32'd0, 32'h6666_6666, 32'h7777_7777);
    send_item(OP_REQUEST, 4'h2, 32'd0, 32'h8888_8888, 32'h9999_9999);
    set_active_servers(5'd17);
    send_item(OP_REQUEST, 4'hC, 32'd2, 32'hDEAD_0000, 32'h0000_BEEF);
    set_active_servers(5'd2);
    send_item(OP_REQUEST, 4'h0, 32'd1, 32'h0000_0001, 32'h8000_0000);
    send_item(OP_REQUEST, 4'h0, 32'd1, 32'h8000_0000, 32'h0000_0001);
  endtask

  task automatic test_random_traffic();
    logic [ACTIVE_W-1:0] setting;
    logic [LOAD_W-1:0]   tval;
    int                  phase;
    int                  n;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: setting = ACTIVE_RESET;
        1: setting = 5'd31;
        2: setting = 5'($urandom_range(2, 15));
        3: setting = 5'd1;
        default: setting = 5'd0;
      endcase
      set_active_servers(setting);
      gaps_on = (phase != 2);
      for (n = 0; n < ((phase < 3) ? 120 : 70); n++) begin
        if (phase == 1 && n == 60) wait_for_results();
        case ($urandom_range(9))
          0, 1, 2, 3: tval = $urandom_range(24);
          4, 5, 6:    tval = $urandom;
          7:          tval = '0;
          8:          tval = LOAD_MAX - $urandom_range(3);
          default:    tval = {1'b1, 31'($urandom_range(24))};
        endcase
        if ($urandom_range(99) < 35)
          send_item(OP_REPORT, 4'($urandom_range(15)), tval, $urandom, $urandom);
        else
          send_item(OP_REQUEST, 4'($urandom_range(15)), tval, $urandom, $urandom);
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready = !gaps_on || ($urandom_range(99) >= 16);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_dispatches
    dispatch_t want;
    if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (pending_dispatches.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual server %0d load %h",
                 $time, res_if.target_server, res_if.load_after);
        errors++;
      end else begin
        want = pending_dispatches.pop_front();
        check_field("target_server", 32'(want.target_server), 32'(res_if.target_server));
        check_field("out_source_address", want.source_address, res_if.out_source_address);
        check_field("out_dest_address", want.dest_address, res_if.out_dest_address);
        check_field("service_time", want.service_time, res_if.service_time);
        check_field("load_after", want.load_after, res_if.load_after);
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    req_if.valid          = 1'b0;
    req_if.operation      = OP_REQUEST;
    req_if.server_index   = '0;
    req_if.time_value     = '0;
    req_if.source_address = '0;
    req_if.dest_address   = '0;
    active_model          = ACTIVE_RESET;
    foreach (server_load_model[i]) server_load_model[i] = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_ties();
    test_load_reports();
    test_active_count();
    test_random_traffic();

    wait_for_results();
    repeat (MAX_SERVERS + 4) @(negedge clk);
    $display("%0d requests and %0d load reports sent, %0d dispatch results checked",
             n_requests, n_reports, n_checked);
    $display("%0d active server settings written, zero and oversized counts among them",
             n_settings);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
